### rtl/tsw_pkg.sv
// ----------------------------------------------------------------------------
// tsw_pkg
// shared constants, codes and controller/datapath interface types for the
// tcp send window buffer
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int BUF_BYTES = 32768;
  localparam int ADDR_W    = 15;
  localparam int SEG_BYTES = 1024;
  localparam int LEN_W     = 11;
  localparam int MAX_SEGS  = 32;
  localparam int SEGN_W    = 5;
  localparam int WIN_W     = 15;
  localparam int PADDR_W   = 4;

  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_ACK    = 3'd1;
  localparam logic [2:0] ACT_SEND   = 3'd2;
  localparam logic [2:0] ACT_RETX   = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;
  localparam logic [2:0] ACT_START  = 3'd5;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_SEG    = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_RETX   = 2'd3;

  localparam logic [1:0] REG_RECV_WIN = 2'd0;
  localparam logic [1:0] REG_CONG_WIN = 2'd1;
  localparam logic [1:0] REG_SEQ_LIM  = 2'd2;

  typedef struct packed {
    logic clr;
    logic append;
    logic set_start;
    logic status;
    logic rd;
    logic ack_begin;
    logic ack_step;
    logic send_none;
    logic send_step;
    logic scan_begin;
    logic scan_step;
  } cmd_t;

  typedef struct packed {
    logic ack_ok;
    logic left_zero;
    logic clr_done;
    logic walk_done;
    logic send_last;
    logic scan_stop;
  } stat_t;

endpackage

### rtl/tsw_ram.sv
// ----------------------------------------------------------------------------
// tsw_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module tsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/tsw_ctrl.sv
// ----------------------------------------------------------------------------
// tsw_ctrl
// sequencing state machine: clearing pass, ack walk, segmenting, mark scan
// ----------------------------------------------------------------------------
module tsw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2:0]     action,
  input  tsw_pkg::stat_t stat,
  output tsw_pkg::cmd_t  cmd,
  output logic           busy
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_ACK   = 3'd2;
  localparam logic [2:0] ST_SEND  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (action)
            tsw_pkg::ACT_APPEND: begin
              cmd.append = 1'b1;
              cmd.status = 1'b1;
            end
            tsw_pkg::ACT_ACK: begin
              if (stat.ack_ok) begin
                cmd.ack_begin = 1'b1;
                state_nxt     = ST_ACK;
              end else begin
                cmd.status = 1'b1;
              end
            end
            tsw_pkg::ACT_SEND: begin
              if (stat.left_zero) begin
                cmd.send_none = 1'b1;
              end else begin
                state_nxt = ST_SEND;
              end
            end
            tsw_pkg::ACT_RETX: begin
              cmd.scan_begin = 1'b1;
              state_nxt      = ST_SCAN;
            end
            tsw_pkg::ACT_READ: begin
              cmd.rd = 1'b1;
            end
            tsw_pkg::ACT_START: begin
              cmd.set_start = 1'b1;
              cmd.status    = 1'b1;
            end
            default: begin
              cmd.status = 1'b1;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_ACK: begin
        cmd.ack_step = 1'b1;
        if (stat.walk_done) state_nxt = ST_IDLE;
      end
      ST_SEND: begin
        cmd.send_step = 1'b1;
        if (stat.send_last) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_stop) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

### rtl/tsw_datapath.sv
// ----------------------------------------------------------------------------
// tsw_datapath
// pointers, window registers, byte and mark stores, result registers
// ----------------------------------------------------------------------------
module tsw_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tsw_pkg::cmd_t                cmd,
  output tsw_pkg::stat_t               stat,
  input  logic [7:0]                   in_data_byte,
  input  logic [tsw_pkg::ADDR_W-1:0]   in_position,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_idx,
  input  logic [31:0]                  cfg_wdata,
  output logic [31:0]                  cfg_rdata,
  output logic                         out_valid,
  output logic [1:0]                   out_kind,
  output logic                         out_accepted,
  output logic [tsw_pkg::ADDR_W-1:0]   out_seq_number,
  output logic [tsw_pkg::LEN_W-1:0]    out_seg_length,
  output logic [7:0]                   out_read_data,
  output logic                         out_empty_res,
  output logic                         out_error,
  output logic                         out_last
);

  localparam int AW = tsw_pkg::ADDR_W;
  localparam int LW = tsw_pkg::LEN_W;
  localparam int WW = tsw_pkg::WIN_W;
  localparam int NW = tsw_pkg::SEGN_W;

  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] next_r, next_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] walk_r, walk_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [NW-1:0] segn_r, segn_nxt;
  logic [WW-1:0] recv_win_r, cong_win_r, seq_lim_r;

  logic          ov_r, ov_nxt;
  logic [1:0]    ok_r, ok_nxt;
  logic          oacc_r, oacc_nxt;
  logic [AW-1:0] oseq_r, oseq_nxt;
  logic [LW-1:0] olen_r, olen_nxt;
  logic          oemp_r, oemp_nxt;
  logic          oerr_r, oerr_nxt;
  logic          olast_r, olast_nxt;

  logic [WW-1:0] win;
  logic          acc;
  logic [AW-1:0] ack_d, sent_d, left;
  logic [LW-1:0] seg_len;
  logic [AW-1:0] seg_end;
  logic          mark_q;
  logic          mark_we, mark_wd, mark_re;
  logic [AW-1:0] mark_addr;
  logic          byte_we, byte_re;
  logic [AW-1:0] byte_addr;
  logic [7:0]    byte_q;

  always_comb begin
    win = recv_win_r;
    if (seq_lim_r < win) win = seq_lim_r;
    if (cong_win_r < win) win = cong_win_r;
  end

  assign acc     = ((fill_r - oldest_r) < AW'(win));
  assign ack_d   = in_position - oldest_r;
  assign sent_d  = next_r - oldest_r;
  assign left    = fill_r - next_r;
  assign seg_len = (left > AW'(tsw_pkg::SEG_BYTES)) ? LW'(tsw_pkg::SEG_BYTES) : left[LW-1:0];
  assign seg_end = next_r + AW'(seg_len);

  assign stat.ack_ok    = (ack_d != '0) && (ack_d <= sent_d);
  assign stat.left_zero = (left == '0);
  assign stat.clr_done  = (clr_r == {AW{1'b1}});
  assign stat.walk_done = (walk_r == pos_r);
  assign stat.send_last = (left == AW'(seg_len)) ||
                          (segn_r == NW'(tsw_pkg::MAX_SEGS - 1));
  assign stat.scan_stop = mark_q || (len_r == LW'(tsw_pkg::SEG_BYTES));

  always_comb begin
    oldest_nxt = oldest_r;
    fill_nxt   = fill_r;
    next_nxt   = next_r;
    pos_nxt    = pos_r;
    walk_nxt   = walk_r;
    clr_nxt    = clr_r;
    len_nxt    = len_r;
    segn_nxt   = segn_r;
    ov_nxt     = 1'b0;
    ok_nxt     = ok_r;
    oacc_nxt   = oacc_r;
    oseq_nxt   = oseq_r;
    olen_nxt   = olen_r;
    oerr_nxt   = oerr_r;
    olast_nxt  = olast_r;
    mark_we    = 1'b0;
    mark_wd    = 1'b0;
    mark_addr  = oldest_r + AW'(len_r + LW'(1));
    byte_we    = 1'b0;
    byte_re    = cmd.rd;
    byte_addr  = cmd.append ? fill_r : in_position;

    if (cmd.append && acc) begin
      byte_we  = 1'b1;
      fill_nxt = fill_r + AW'(1);
    end
    if (cmd.set_start) begin
      oldest_nxt = in_position;
      fill_nxt   = in_position;
      next_nxt   = in_position;
    end
    if (cmd.status || cmd.rd || cmd.send_none) begin
      ov_nxt    = 1'b1;
      ok_nxt    = cmd.rd ? tsw_pkg::KIND_READ :
                  (cmd.send_none ? tsw_pkg::KIND_SEG : tsw_pkg::KIND_STATUS);
      oacc_nxt  = cmd.append && acc;
      oseq_nxt  = cmd.send_none ? next_r : '0;
      olen_nxt  = '0;
      oerr_nxt  = 1'b0;
      olast_nxt = 1'b1;
    end
    if (cmd.clr) begin
      mark_we   = 1'b1;
      mark_addr = clr_r;
      clr_nxt   = clr_r + AW'(1);
    end
    if (cmd.ack_begin) begin
      pos_nxt  = in_position;
      walk_nxt = oldest_r;
    end
    if (cmd.ack_step) begin
      mark_we   = 1'b1;
      mark_addr = walk_r;
      walk_nxt  = walk_r + AW'(1);
      if (stat.walk_done) begin
        oldest_nxt = pos_r;
        ov_nxt     = 1'b1;
        ok_nxt     = tsw_pkg::KIND_STATUS;
        oacc_nxt   = 1'b0;
        oseq_nxt   = '0;
        olen_nxt   = '0;
        oerr_nxt   = 1'b0;
        olast_nxt  = 1'b1;
      end
    end
    if (cmd.send_step) begin
      mark_we   = 1'b1;
      mark_wd   = 1'b1;
      mark_addr = seg_end;
      next_nxt  = seg_end;
      segn_nxt  = stat.send_last ? '0 : segn_r + NW'(1);
      ov_nxt    = 1'b1;
      ok_nxt    = tsw_pkg::KIND_SEG;
      oacc_nxt  = 1'b0;
      oseq_nxt  = next_r;
      olen_nxt  = seg_len;
      oerr_nxt  = 1'b0;
      olast_nxt = stat.send_last;
    end
    if (cmd.scan_begin) begin
      len_nxt   = '0;
      mark_addr = oldest_r;
    end
    if (cmd.scan_step) begin
      len_nxt = len_r + LW'(1);
      if (stat.scan_stop) begin
        ov_nxt    = 1'b1;
        ok_nxt    = tsw_pkg::KIND_RETX;
        oacc_nxt  = 1'b0;
        oseq_nxt  = oldest_r;
        olen_nxt  = mark_q ? len_r : '0;
        oerr_nxt  = !mark_q;
        olast_nxt = 1'b1;
      end
    end
    oemp_nxt = (oldest_nxt == fill_nxt);
    mark_re  = !mark_we;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r   <= '0;
      fill_r     <= '0;
      next_r     <= '0;
      clr_r      <= '0;
      segn_r     <= '0;
      ov_r       <= 1'b0;
      recv_win_r <= WW'(32767);
      cong_win_r <= WW'(1024);
      seq_lim_r  <= WW'(15000);
    end else begin
      oldest_r <= oldest_nxt;
      fill_r   <= fill_nxt;
      next_r   <= next_nxt;
      clr_r    <= clr_nxt;
      segn_r   <= segn_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          tsw_pkg::REG_RECV_WIN: recv_win_r <= cfg_wdata[WW-1:0];
          tsw_pkg::REG_CONG_WIN: cong_win_r <= cfg_wdata[WW-1:0];
          tsw_pkg::REG_SEQ_LIM:  seq_lim_r  <= cfg_wdata[WW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    walk_r  <= walk_nxt;
    len_r   <= len_nxt;
    ok_r    <= ok_nxt;
    oacc_r  <= oacc_nxt;
    oseq_r  <= oseq_nxt;
    olen_r  <= olen_nxt;
    oemp_r  <= oemp_nxt;
    oerr_r  <= oerr_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    case (cfg_idx)
      tsw_pkg::REG_RECV_WIN: cfg_rdata = {{(32-WW){1'b0}}, recv_win_r};
      tsw_pkg::REG_CONG_WIN: cfg_rdata = {{(32-WW){1'b0}}, cong_win_r};
      tsw_pkg::REG_SEQ_LIM:  cfg_rdata = {{(32-WW){1'b0}}, seq_lim_r};
      default:               cfg_rdata = '0;
    endcase
  end

  tsw_ram #(.WIDTH(8), .DEPTH(tsw_pkg::BUF_BYTES)) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .re    (byte_re),
    .addr  (byte_addr),
    .wdata (in_data_byte),
    .rdata (byte_q)
  );

  tsw_ram #(.WIDTH(1), .DEPTH(tsw_pkg::BUF_BYTES)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .re    (mark_re),
    .addr  (mark_addr),
    .wdata (mark_wd),
    .rdata (mark_q)
  );

  assign out_valid      = ov_r;
  assign out_kind       = ok_r;
  assign out_accepted   = oacc_r;
  assign out_seq_number = oseq_r;
  assign out_seg_length = olen_r;
  assign out_read_data  = (ok_r == tsw_pkg::KIND_READ) ? byte_q : 8'd0;
  assign out_empty_res  = oemp_r;
  assign out_error      = oerr_r;
  assign out_last       = olast_r;

endmodule

### rtl/tcp_send_window_buffer.sv
// ----------------------------------------------------------------------------
// tcp_send_window_buffer
// circular tcp send buffer with window check, segmenting, ack and retransmit
// ----------------------------------------------------------------------------
// a transaction is taken when start is high and busy is low; in_action picks
// append, ack, send, retransmit, read byte or set start
// every result shows on the out_ ports for one cycle with out_valid high;
// out_last marks the final result of a transaction; there is no back pressure
// append, read, set start and ignored acks: the result is registered and shows
// in the cycle after the transaction; the next one may follow straight away
// send: one segment descriptor a cycle, up to 32, with busy high while segmenting
// ack: one boundary mark cleared a cycle (distance plus one), then status
// retransmit: one mark position scanned a cycle, up to 1025 positions
// the mark store has a single port, which sets the ack and scan walk rates
// after reset a clearing pass wipes all 32768 mark store entries with busy
// high; window registers on the apb port are writable throughout
// ----------------------------------------------------------------------------
module tcp_send_window_buffer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_action,
  input  logic [7:0]                    in_data_byte,
  input  logic [tsw_pkg::ADDR_W-1:0]    in_position,
  output logic                          out_valid,
  output logic [1:0]                    out_kind,
  output logic                          out_accepted,
  output logic [tsw_pkg::ADDR_W-1:0]    out_seq_number,
  output logic [tsw_pkg::LEN_W-1:0]     out_seg_length,
  output logic [7:0]                    out_read_data,
  output logic                          out_empty_res,
  output logic                          out_error,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsw_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  tsw_pkg::cmd_t  cmd;
  tsw_pkg::stat_t stat;
  logic           go;

  assign pready = 1'b1;
  assign go     = start && !busy;

  tsw_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (go),
    .action (in_action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  tsw_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_data_byte   (in_data_byte),
    .in_position    (in_position),
    .cfg_we         (psel && penable && pwrite),
    .cfg_idx        (paddr[3:2]),
    .cfg_wdata      (pwdata),
    .cfg_rdata      (prdata),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_accepted   (out_accepted),
    .out_seq_number (out_seq_number),
    .out_seg_length (out_seg_length),
    .out_read_data  (out_read_data),
    .out_empty_res  (out_empty_res),
    .out_error      (out_error),
    .out_last       (out_last)
  );

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("clearing pass not entered after reset");

  a_append_result: assert property (@(posedge clk) disable iff (!rst_n)
    go && (in_action == tsw_pkg::ACT_APPEND) |=> out_valid && out_last)
    else $error("append gave no status");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != tsw_pkg::KIND_SEG) |-> out_last)
    else $error("non segment result without last");

  a_seg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == tsw_pkg::KIND_SEG) && !out_last |-> busy)
    else $error("segmenting stopped early");

endmodule
